/* rtl/gjd_pkg.sv */
// Shared types, constants and lookup tables for the Gregorian / Julian day converter.
package gjd_pkg;

    localparam int unsigned GJD_LAT = 16;

    localparam logic [28:0] JDN_MIN = 29'd2299161;
    localparam logic [28:0] JDN_MAX = 29'd536800999;
    localparam logic [20:0] YEAR_FIRST = 21'd1582;
    localparam logic [20:0] YEAR_LAST = 21'd1464999;

    localparam logic [17:0] DIV_CENT = 18'd146097;
    localparam logic [20:0] DIV_YEAR = 21'd1461001;
    localparam logic [11:0] DIV_MON = 12'd2447;

    localparam logic [14:0] MAG_CENT = 15'((64'd1 << 32) / 64'd146097);
    localparam logic [7:0] MAG_YEAR = 8'((64'd1 << 28) / 64'd1461001);
    localparam logic [5:0] MAG_MON = 6'((64'd1 << 17) / 64'd2447);
    localparam logic [30:0] MAG_100 = 31'h51EB851F;

    localparam logic [8:0] MONTH_OFF [16] = '{
        9'd0,
        9'(367 * 11 / 12), 9'(367 * 12 / 12), 9'(367 * 1 / 12), 9'(367 * 2 / 12),
        9'(367 * 3 / 12), 9'(367 * 4 / 12), 9'(367 * 5 / 12), 9'(367 * 6 / 12),
        9'(367 * 7 / 12), 9'(367 * 8 / 12), 9'(367 * 9 / 12), 9'(367 * 10 / 12),
        9'd0, 9'd0, 9'd0
    };

    localparam logic [8:0] DAY_OFF [16] = '{
        9'(2447 * 0 / 80), 9'(2447 * 1 / 80), 9'(2447 * 2 / 80), 9'(2447 * 3 / 80),
        9'(2447 * 4 / 80), 9'(2447 * 5 / 80), 9'(2447 * 6 / 80), 9'(2447 * 7 / 80),
        9'(2447 * 8 / 80), 9'(2447 * 9 / 80), 9'(2447 * 10 / 80), 9'(2447 * 11 / 80),
        9'(2447 * 12 / 80), 9'(2447 * 13 / 80), 9'(2447 * 14 / 80), 9'(2447 * 15 / 80)
    };

    typedef struct packed {
        logic [28:0] day_number;
        logic        ok;
    } gjd_day_res_t;

    typedef struct packed {
        logic [20:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        ok;
    } gjd_date_res_t;

endpackage

/* rtl/gjd_date_to_day.sv */
// Pipelined Gregorian date to Julian day number lane.
module gjd_date_to_day
    import gjd_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [20:0]   year,
    input  logic [3:0]    month,
    input  logic [5:0]    day,
    output gjd_day_res_t  res
);

    localparam int unsigned PAD = GJD_LAT - 4;

    logic        good_m;
    logic        good_d;
    logic        big;
    logic        early;
    logic        jan_feb;

    logic        ok1_reg;
    logic [21:0] y1_reg;
    logic [21:0] y2_reg;
    logic [8:0]  moff1_reg;
    logic [5:0]  d1_reg;

    logic        ok2_reg;
    logic [31:0] p2_reg;
    logic [52:0] q2_reg;
    logic [8:0]  moff2_reg;
    logic [5:0]  d2_reg;

    logic        ok3_reg;
    logic [29:0] term1_reg;
    logic [15:0] term3_reg;
    logic [8:0]  moff3_reg;
    logic [5:0]  d3_reg;

    logic [31:0]  sum4;
    gjd_day_res_t res4_reg;
    gjd_day_res_t dly_reg [PAD];

    always_comb
    begin
        good_m = (month >= 4'd1) && (month <= 4'd12);
        good_d = (day >= 6'd1) && (day <= 6'd31);
        big = (year > YEAR_FIRST) ||
              ((year == YEAR_FIRST) && ((month > 4'd10) || ((month == 4'd10) && (day >= 6'd15))));
        early = (year < YEAR_LAST) ||
                ((year == YEAR_LAST) && ((month < 4'd2) || ((month == 4'd2) && (day <= 6'd11))));
        jan_feb = (month <= 4'd2);
        sum4 = {26'd0, d3_reg} + {2'd0, term1_reg} + {23'd0, moff3_reg}
             - {16'd0, term3_reg} - 32'd32075;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok1_reg <= good_m && good_d && big && early;
            y1_reg <= {1'b0, year} + (jan_feb ? 22'd4799 : 22'd4800);
            y2_reg <= {1'b0, year} + (jan_feb ? 22'd4899 : 22'd4900);
            moff1_reg <= MONTH_OFF[month];
            d1_reg <= day;

            ok2_reg <= ok1_reg;
            p2_reg <= {10'd0, y1_reg} * 32'd1461;
            q2_reg <= {31'd0, y2_reg} * {22'd0, MAG_100};
            moff2_reg <= moff1_reg;
            d2_reg <= d1_reg;

            ok3_reg <= ok2_reg;
            term1_reg <= p2_reg[31:2];
            term3_reg <= 16'(({2'd0, q2_reg[52:37]} * 18'd3) >> 2);
            moff3_reg <= moff2_reg;
            d3_reg <= d2_reg;

            res4_reg.ok <= ok3_reg;
            res4_reg.day_number <= ok3_reg ? sum4[28:0] : 29'd0;

            dly_reg[0] <= res4_reg;
            for (int i = 1; i < PAD; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign res = dly_reg[PAD-1];

endmodule

/* rtl/gjd_day_to_date.sv */
// Pipelined Julian day number to Gregorian date lane.
module gjd_day_to_date
    import gjd_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [28:0]   day_number,
    output gjd_date_res_t res
);

    logic        ok_reg [GJD_LAT];

    logic [29:0] t1_reg;
    logic [29:0] t2_reg;
    logic [46:0] prod2_reg;
    logic [29:0] t3_reg;
    logic [14:0] c0_3_reg;
    logic [31:0] back3_reg;
    logic [14:0] c0_4_reg;
    logic [31:0] r4_reg;

    logic [32:0] rd5;
    logic        corr5;
    logic [31:0] rem5;
    logic [14:0] c5_reg;
    logic [15:0] t2_5_reg;

    logic [27:0] n6_reg;
    logic [20:0] cy6_reg;
    logic [15:0] t2_6_reg;
    logic [35:0] prod7_reg;
    logic [27:0] n7_reg;
    logic [20:0] cy7_reg;
    logic [15:0] t2_7_reg;
    logic [7:0]  yy0_8_reg;
    logic [27:0] back8_reg;
    logic [27:0] n8_reg;
    logic [20:0] cy8_reg;
    logic [15:0] t2_8_reg;

    logic [27:0] r9;
    logic [7:0]  yy9_reg;
    logic [20:0] cy9_reg;
    logic [15:0] t2_9_reg;
    logic [18:0] p10_reg;
    logic [7:0]  yy10_reg;
    logic [20:0] cy10_reg;
    logic [15:0] t2_10_reg;
    logic [9:0]  t3_11_reg;
    logic [7:0]  yy11_reg;
    logic [20:0] cy11_reg;
    logic [16:0] n12_reg;
    logic [9:0]  t3_12_reg;
    logic [7:0]  yy12_reg;
    logic [20:0] cy12_reg;
    logic [22:0] prod13_reg;
    logic [16:0] n13_reg;
    logic [9:0]  t3_13_reg;
    logic [7:0]  yy13_reg;
    logic [20:0] cy13_reg;
    logic [5:0]  mm0_14_reg;
    logic [16:0] back14_reg;
    logic [16:0] n14_reg;
    logic [9:0]  t3_14_reg;
    logic [7:0]  yy14_reg;
    logic [20:0] cy14_reg;

    logic [16:0] r15;
    logic [3:0]  mm15_reg;
    logic [9:0]  t3_15_reg;
    logic [7:0]  yy15_reg;
    logic [20:0] cy15_reg;

    logic        k16;
    logic        ok16;

    always_comb
    begin
        rd5 = {1'b0, r4_reg} - {15'd0, DIV_CENT};
        corr5 = !rd5[32];
        rem5 = corr5 ? rd5[31:0] : r4_reg;
        r9 = n8_reg - back8_reg;
        r15 = n14_reg - back14_reg;
        k16 = (mm15_reg >= 4'd11);
        ok16 = ok_reg[GJD_LAT-2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg[0] <= (day_number >= JDN_MIN) && (day_number <= JDN_MAX);
            for (int i = 1; i < GJD_LAT; i++)
            begin
                ok_reg[i] <= ok_reg[i-1];
            end

            t1_reg <= {1'b0, day_number} + 30'd68569;

            prod2_reg <= {15'd0, t1_reg, 2'b00} * {32'd0, MAG_CENT};
            t2_reg <= t1_reg;

            c0_3_reg <= prod2_reg[46:32];
            back3_reg <= 32'({17'd0, prod2_reg[46:32]} * {14'd0, DIV_CENT});
            t3_reg <= t2_reg;

            c0_4_reg <= c0_3_reg;
            r4_reg <= {t3_reg, 2'b00} - back3_reg;

            c5_reg <= c0_4_reg + {14'd0, corr5};
            t2_5_reg <= rem5[17:2];

            n6_reg <= 28'(({12'd0, t2_5_reg} + 28'd1) * 28'd4000);
            cy6_reg <= 21'(({6'd0, c5_reg} - 21'd49) * 21'd100);
            t2_6_reg <= t2_5_reg;

            prod7_reg <= {8'd0, n6_reg} * {28'd0, MAG_YEAR};
            n7_reg <= n6_reg;
            cy7_reg <= cy6_reg;
            t2_7_reg <= t2_6_reg;

            yy0_8_reg <= prod7_reg[35:28];
            back8_reg <= 28'({20'd0, prod7_reg[35:28]} * {7'd0, DIV_YEAR});
            n8_reg <= n7_reg;
            cy8_reg <= cy7_reg;
            t2_8_reg <= t2_7_reg;

            yy9_reg <= yy0_8_reg + {7'd0, (r9 >= {7'd0, DIV_YEAR})};
            cy9_reg <= cy8_reg;
            t2_9_reg <= t2_8_reg;

            p10_reg <= {11'd0, yy9_reg} * 19'd1461;
            yy10_reg <= yy9_reg;
            cy10_reg <= cy9_reg;
            t2_10_reg <= t2_9_reg;

            t3_11_reg <= 10'({1'b0, t2_10_reg} - p10_reg[18:2] + 17'd31);
            yy11_reg <= yy10_reg;
            cy11_reg <= cy10_reg;

            n12_reg <= {7'd0, t3_11_reg} * 17'd80;
            t3_12_reg <= t3_11_reg;
            yy12_reg <= yy11_reg;
            cy12_reg <= cy11_reg;

            prod13_reg <= {6'd0, n12_reg} * {17'd0, MAG_MON};
            n13_reg <= n12_reg;
            t3_13_reg <= t3_12_reg;
            yy13_reg <= yy12_reg;
            cy13_reg <= cy12_reg;

            mm0_14_reg <= prod13_reg[22:17];
            back14_reg <= 17'({11'd0, prod13_reg[22:17]} * {5'd0, DIV_MON});
            n14_reg <= n13_reg;
            t3_14_reg <= t3_13_reg;
            yy14_reg <= yy13_reg;
            cy14_reg <= cy13_reg;

            mm15_reg <= 4'(mm0_14_reg + {5'd0, (r15 >= {5'd0, DIV_MON})});
            t3_15_reg <= t3_14_reg;
            yy15_reg <= yy14_reg;
            cy15_reg <= cy14_reg;

            res.ok <= ok16;
            res.day <= ok16 ? 5'(t3_15_reg - {1'b0, DAY_OFF[mm15_reg]}) : 5'd0;
            res.month <= ok16 ? (mm15_reg + 4'd2 - (k16 ? 4'd12 : 4'd0)) : 4'd0;
            res.year <= ok16 ? (cy15_reg + {13'd0, yy15_reg} + {20'd0, k16}) : 21'd0;
        end
    end

endmodule

/* rtl/gregorian_julian_day_converter_unit.sv */
// Top level: Gregorian date / Julian day number converter with valid-ready channels.
//
// Input channel: in_valid / in_ready carry one transaction with action, in_year, in_month,
// in_day and in_day_number. Action 0 turns the date into a Julian day number, action 1
// turns in_day_number into a Gregorian date; the unused fields of a result are zero.
// Output channel: out_valid / out_ready carry out_day_number, out_year, out_month, out_day
// and valid_res, which is low (with all result fields zero) for a rejected input.
// Every accepted transaction gives exactly one result, in order.
// Pipeline: the 16-stage day-to-date lane, whose first stage loads at the accepting edge
// (three reciprocal divides, each a multiply, a multiply-back and a correction step),
// then the output register.
// Throughput: one transaction per cycle while out_ready is high.
// Stall: when the output register holds an untaken result, in_ready drops and the whole
// pipeline holds; nothing is lost or repeated.
// Reset: rst_n clears the pipeline valid bits and out_valid; the pipeline is empty after it.
module gregorian_julian_day_converter_unit
    import gjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [20:0] in_year,
    input  logic [3:0]  in_month,
    input  logic [5:0]  in_day,
    input  logic [28:0] in_day_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [28:0] out_day_number,
    output logic [20:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic        valid_res
);

    logic               en;
    logic [GJD_LAT-1:0] v_reg;
    logic [GJD_LAT-1:0] act_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    gjd_day_res_t       day_res;
    gjd_date_res_t      date_res;
    logic [28:0]        day_number_reg;
    logic [20:0]        year_reg;
    logic [3:0]         month_reg;
    logic [4:0]         day_reg;
    logic               valid_res_reg;

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    gjd_date_to_day u_date_to_day (
        .clk   (clk),
        .en    (en),
        .year  (in_year),
        .month (in_month),
        .day   (in_day),
        .res   (day_res)
    );

    gjd_day_to_date u_day_to_date (
        .clk        (clk),
        .en         (en),
        .day_number (in_day_number),
        .res        (date_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (en)
        begin
            out_valid_next = v_reg[GJD_LAT-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (en)
            begin
                v_reg <= {v_reg[GJD_LAT-2:0], in_valid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_reg <= {act_reg[GJD_LAT-2:0], action};
            if (act_reg[GJD_LAT-1])
            begin
                day_number_reg <= 29'd0;
                year_reg <= date_res.year;
                month_reg <= date_res.month;
                day_reg <= date_res.day;
                valid_res_reg <= date_res.ok;
            end
            else
            begin
                day_number_reg <= day_res.day_number;
                year_reg <= 21'd0;
                month_reg <= 4'd0;
                day_reg <= 5'd0;
                valid_res_reg <= day_res.ok;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_day_number = day_number_reg;
    assign out_year = year_reg;
    assign out_month = month_reg;
    assign out_day = day_reg;
    assign valid_res = valid_res_reg;

endmodule
